@@ hdl/csvft_pkg.sv @@
// shared types and constants for the csv field tokenizer
// no dependencies

package csvft_pkg;

    localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic [7:0] DELIMITER_RESET = 8'd44;

    typedef enum logic [0:0] {
        CFG_QUOTE     = 1'b0,
        CFG_DELIMITER = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_INITIAL  = 3'd0,
        PH_READING  = 3'd1,
        PH_UNQUOTED = 3'd2,
        PH_QUOTED   = 3'd3,
        PH_FOUNDQ   = 3'd4,
        PH_DROP     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_UNTERMINATED = 2'd1,
        ERR_AFTER_QUOTE = 2'd2
    } error_code_t;

    typedef struct packed {
        logic        has_word;
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        field_end;
        logic        record_end;
        error_code_t error_code;
    } result_t;

endpackage

@@ hdl/csv_field_tokenizer.sv @@
// an accepted word is registered at the input, its result word in out_reg
// throughput: one word per cycle unless in_stall; no result means no output word
// in_stall = out_stall while both stages hold words and the input one has a result
// reset: phase returns to initial, quote to 34, delimiter to 44, both stages empty
// top level of the csv field tokenizer; depends on csvft_pkg and csvft_step

module csv_field_tokenizer
    import csvft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_valid,
    output logic [7:0] out_byte,
    output logic       field_end,
    output logic       record_end,
    output logic [1:0] error_code
);

    logic [7:0] quote_reg;
    logic [7:0] delimiter_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    logic       out_vld_reg;
    result_t    out_reg;
    result_t    result;
    logic       advance;

    csvft_step u_step (
        .phase          (phase_reg),
        .in_byte        (in_byte_reg),
        .end_of_input   (in_eoi_reg),
        .quote_char     (quote_reg),
        .delimiter_char (delimiter_reg),
        .phase_next     (phase_next),
        .result         (result)
    );

    assign advance  = in_vld_reg && (!result.has_word || !out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg     <= QUOTE_RESET;
            delimiter_reg <= DELIMITER_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_QUOTE:     quote_reg     <= cfg_data;
                CFG_DELIMITER: delimiter_reg <= cfg_data;
                default:       quote_reg     <= quote_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_INITIAL;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (advance)
                phase_reg <= phase_next;
            if (advance && result.has_word)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= in_byte;
            in_eoi_reg  <= end_of_input;
        end
        if (advance && result.has_word)
            out_reg <= result;
    end

    assign out_valid  = out_vld_reg;
    assign byte_valid = out_reg.byte_valid;
    assign out_byte   = out_reg.out_byte;
    assign field_end  = out_reg.field_end;
    assign record_end = out_reg.record_end;
    assign error_code = out_reg.error_code;

endmodule

@@ hdl/csvft_step.sv @@
// parse phase transition and result word for one input word
// depends on csvft_pkg

module csvft_step
    import csvft_pkg::*;
(
    input  phase_t     phase,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    input  logic [7:0] quote_char,
    input  logic [7:0] delimiter_char,
    output phase_t     phase_next,
    output result_t    result
);

    logic is_nl;
    logic is_quote;
    logic is_delim;

    assign is_nl    = (in_byte == NEWLINE_BYTE);
    assign is_quote = (in_byte == quote_char);
    assign is_delim = (in_byte == delimiter_char);

    always_comb
    begin
        phase_next = phase;
        result     = '{has_word: 1'b0, byte_valid: 1'b0, out_byte: 8'd0,
                       field_end: 1'b0, record_end: 1'b0, error_code: ERR_NONE};
        case (phase)
            PH_READING, PH_UNQUOTED:
            begin
                if (end_of_input)
                begin
                    phase_next       = PH_INITIAL;
                    result.has_word  = 1'b1;
                    result.field_end = 1'b1;
                end
                else if (is_nl)
                begin
                    phase_next        = PH_INITIAL;
                    result.has_word   = 1'b1;
                    result.field_end  = 1'b1;
                    result.record_end = 1'b1;
                end
                else if (phase == PH_READING && is_quote)
                begin
                    phase_next = PH_QUOTED;
                end
                else if (is_delim)
                begin
                    phase_next       = PH_READING;
                    result.has_word  = 1'b1;
                    result.field_end = 1'b1;
                end
                else
                begin
                    phase_next        = PH_UNQUOTED;
                    result.has_word   = 1'b1;
                    result.byte_valid = 1'b1;
                    result.out_byte   = in_byte;
                end
            end
            PH_QUOTED:
            begin
                if (end_of_input)
                begin
                    phase_next        = PH_INITIAL;
                    result.has_word   = 1'b1;
                    result.error_code = ERR_UNTERMINATED;
                end
                else if (is_quote)
                begin
                    phase_next = PH_FOUNDQ;
                end
                else
                begin
                    result.has_word   = 1'b1;
                    result.byte_valid = 1'b1;
                    result.out_byte   = in_byte;
                end
            end
            PH_FOUNDQ:
            begin
                if (end_of_input)
                begin
                    phase_next       = PH_INITIAL;
                    result.has_word  = 1'b1;
                    result.field_end = 1'b1;
                end
                else if (is_nl)
                begin
                    phase_next        = PH_INITIAL;
                    result.has_word   = 1'b1;
                    result.field_end  = 1'b1;
                    result.record_end = 1'b1;
                end
                else if (is_quote)
                begin
                    phase_next        = PH_QUOTED;
                    result.has_word   = 1'b1;
                    result.byte_valid = 1'b1;
                    result.out_byte   = in_byte;
                end
                else if (is_delim)
                begin
                    phase_next       = PH_READING;
                    result.has_word  = 1'b1;
                    result.field_end = 1'b1;
                end
                else
                begin
                    phase_next        = PH_DROP;
                    result.has_word   = 1'b1;
                    result.error_code = ERR_AFTER_QUOTE;
                end
            end
            PH_DROP:
            begin
                if (end_of_input)
                    phase_next = PH_INITIAL;
            end
            default:
            begin
                if (end_of_input || is_nl)
                begin
                    phase_next = PH_INITIAL;
                end
                else if (is_quote)
                begin
                    phase_next = PH_QUOTED;
                end
                else if (is_delim)
                begin
                    phase_next       = PH_READING;
                    result.has_word  = 1'b1;
                    result.field_end = 1'b1;
                end
                else
                begin
                    phase_next        = PH_UNQUOTED;
                    result.has_word   = 1'b1;
                    result.byte_valid = 1'b1;
                    result.out_byte   = in_byte;
                end
            end
        endcase
    end

endmodule

@@ verif/csv_token_checker.sv @@
// checker for the csv field tokenizer: watches the config port and both word channels,
// predicts each result word from its own parse state and compares it field by field
// depends on csvft_pkg
`timescale 1ns / 100ps

module csv_token_checker
    import csvft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       byte_valid,
    input  logic [7:0] out_byte,
    input  logic       field_end,
    input  logic       record_end,
    input  logic [1:0] error_code,
    output int         mismatches,
    output int         pending
);

    phase_t     parse_phase;
    logic [7:0] quote_char;
    logic [7:0] delim_char;
    result_t    token_queue[$];
    result_t    want;
    result_t    token;

    task automatic report_mismatch(input string what, input int got, input int exp);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp, $time);
        mismatches++;
    endtask

    function automatic result_t make_token(input logic bv, input logic [7:0] b,
                                           input logic fe, input logic re,
                                           input error_code_t err);
        result_t r;
        r            = '0;
        r.has_word   = 1'b1;
        r.byte_valid = bv;
        r.out_byte   = bv ? b : 8'd0;
        r.field_end  = fe;
        r.record_end = re;
        r.error_code = err;
        return r;
    endfunction

    // advances the parse phase by one word; returns 1 when a result word follows
    function automatic logic tokenize_word(input logic [7:0] ch, input logic eoi,
                                           output result_t r);
        logic nl;
        nl = (ch == NEWLINE_BYTE);
        r  = '0;
        case (parse_phase)
            PH_READING, PH_UNQUOTED:
            begin
                if (eoi)
                begin
                    parse_phase = PH_INITIAL;
                    r = make_token(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                end
                else if (nl)
                begin
                    parse_phase = PH_INITIAL;
                    r = make_token(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
                end
                else if (parse_phase == PH_READING && ch == quote_char)
                begin
                    parse_phase = PH_QUOTED;
                    return 1'b0;
                end
                else if (ch == delim_char)
                begin
                    parse_phase = PH_READING;
                    r = make_token(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                end
                else
                begin
                    parse_phase = PH_UNQUOTED;
                    r = make_token(1'b1, ch, 1'b0, 1'b0, ERR_NONE);
                end
                return 1'b1;
            end
            PH_QUOTED:
            begin
                if (eoi)
                begin
                    parse_phase = PH_INITIAL;
                    r = make_token(1'b0, 8'd0, 1'b0, 1'b0, ERR_UNTERMINATED);
                end
                else if (ch == quote_char)
                begin
                    parse_phase = PH_FOUNDQ;
                    return 1'b0;
                end
                else
                    r = make_token(1'b1, ch, 1'b0, 1'b0, ERR_NONE);
                return 1'b1;
            end
            PH_FOUNDQ:
            begin
                if (eoi)
                begin
                    parse_phase = PH_INITIAL;
                    r = make_token(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                end
                else if (nl)
                begin
                    parse_phase = PH_INITIAL;
                    r = make_token(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
                end
                else if (ch == quote_char)
                begin
                    parse_phase = PH_QUOTED;
                    r = make_token(1'b1, ch, 1'b0, 1'b0, ERR_NONE);
                end
                else if (ch == delim_char)
                begin
                    parse_phase = PH_READING;
                    r = make_token(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                end
                else
                begin
                    parse_phase = PH_DROP;
                    r = make_token(1'b0, 8'd0, 1'b0, 1'b0, ERR_AFTER_QUOTE);
                end
                return 1'b1;
            end
            PH_DROP:
            begin
                if (eoi)
                    parse_phase = PH_INITIAL;
                return 1'b0;
            end
            default:
            begin
                if (eoi || nl)
                begin
                    parse_phase = PH_INITIAL;
                    return 1'b0;
                end
                else if (ch == quote_char)
                begin
                    parse_phase = PH_QUOTED;
                    return 1'b0;
                end
                else if (ch == delim_char)
                begin
                    parse_phase = PH_READING;
                    r = make_token(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                end
                else
                begin
                    parse_phase = PH_UNQUOTED;
                    r = make_token(1'b1, ch, 1'b0, 1'b0, ERR_NONE);
                end
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_INITIAL;
            quote_char  = QUOTE_RESET;
            delim_char  = DELIMITER_RESET;
            token_queue.delete();
            pending     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (token_queue.size() == 0)
                    report_mismatch("word with none expected", out_byte, -1);
                else
                begin
                    want = token_queue.pop_front();
                    if (byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", byte_valid, want.byte_valid);
                    if (out_byte !== want.out_byte)
                        report_mismatch("out_byte", out_byte, want.out_byte);
                    if (field_end !== want.field_end)
                        report_mismatch("field_end", field_end, want.field_end);
                    if (record_end !== want.record_end)
                        report_mismatch("record_end", record_end, want.record_end);
                    if (error_code !== want.error_code)
                        report_mismatch("error_code", error_code, want.error_code);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (tokenize_word(in_byte, end_of_input, token))
                    token_queue.push_back(token);
            end
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_QUOTE:     quote_char = cfg_data;
                    CFG_DELIMITER: delim_char = cfg_data;
                    default:       ;
                endcase
            end
            pending = token_queue.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// top of the csv field tokenizer testbench: clock, reset, config writes and byte stimulus
// with random idling on both channels; depends on csvft_pkg, csv_field_tokenizer and
// csv_token_checker, which does all prediction and comparison
`timescale 1ns / 100ps

module tb_top
    import csvft_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       out_valid;
    logic       out_stall;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       field_end;
    logic       record_end;
    logic [1:0] error_code;
    int         mismatches;
    int         pending;

    logic       in_fire;
    logic       calm;
    logic       hold_go;
    logic       hold_used;
    logic [7:0] cur_quote;
    logic [7:0] cur_delim;
    int         words_sent;

    logic [7:0] quote_set[7] = '{8'd34, 8'd39, 8'd0,   8'd255, 8'd10,  8'd34, 8'd7};
    logic [7:0] delim_set[7] = '{8'd44, 8'd59, 8'd255, 8'd0,   8'd44,  8'd10, 8'd7};

    csv_field_tokenizer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_valid   (byte_valid),
        .out_byte     (out_byte),
        .field_end    (field_end),
        .record_end   (record_end),
        .error_code   (error_code)
    );

    csv_token_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_valid   (byte_valid),
        .out_byte     (out_byte),
        .field_end    (field_end),
        .record_end   (record_end),
        .error_code   (error_code),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_valid && !in_stall;
    end

    // receiver: random stall, one long hold-off on request, none while calm
    initial
    begin
        out_stall = 1'b0;
        hold_used = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_used)
            begin
                hold_used = 1'b1;
                out_stall <= 1'b1;
                repeat (399) @(negedge clk);
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 26);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eoi);
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        @(negedge clk);
        while (!in_fire) @(negedge clk);
        words_sent++;
    endtask

    task automatic send_eoi();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] q, input logic [7:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_QUOTE;
        cfg_data  <= q;
        @(negedge clk);
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= d;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        cur_quote = q;
        cur_delim = d;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cur_quote || b == cur_delim || b == NEWLINE_BYTE);
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cur_quote);
        return b;
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0:       send_word(8'($urandom_range(0, 255)), 1'b0);
            1:       send_word(cur_quote, 1'b0);
            2:       send_word(cur_delim, 1'b0);
            3:       send_word(NEWLINE_BYTE, 1'b0);
            default: send_eoi();
        endcase
    endtask

    // mostly well-formed records with random content, some noise in between
    task automatic send_records(input int count);
        int stop_at;
        int fields;
        int len;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 12)
                send_noise();
            else
            begin
                fields = $urandom_range(1, 4);
                for (int f = 0; f < fields; f++)
                begin
                    if (f != 0)
                        send_word(cur_delim, 1'b0);
                    len = $urandom_range(0, 5);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        send_word(cur_quote, 1'b0);
                        for (int i = 0; i < len; i++)
                        begin
                            if ($urandom_range(0, 5) == 0)
                            begin
                                send_word(cur_quote, 1'b0);
                                send_word(cur_quote, 1'b0);
                            end
                            else
                                send_word(quoted_byte(), 1'b0);
                        end
                        send_word(cur_quote, 1'b0);
                    end
                    else
                    begin
                        for (int i = 0; i < len; i++)
                            send_word(plain_byte(), 1'b0);
                    end
                end
                if ($urandom_range(0, 99) < 85)
                    send_word(NEWLINE_BYTE, 1'b0);
                else
                    send_eoi();
            end
        end
    endtask

    task automatic run_directed();
        send_eoi();
        send_word(NEWLINE_BYTE, 1'b0);
        send_word(8'h00, 1'b0);
        send_text("\"");
        send_text(",\"");
        send_word(8'hFF, 1'b0);
        send_word(NEWLINE_BYTE, 1'b0);
        send_text("\"\"\",,");
        send_word(NEWLINE_BYTE, 1'b0);
        send_text(",");
        send_eoi();
        send_text("\"");
        send_eoi();
        send_text("\"a\"");
        send_word(NEWLINE_BYTE, 1'b0);
        send_text("\"\"");
        send_eoi();
        send_text("\"\"x");
        send_text("y");
        send_word(NEWLINE_BYTE, 1'b0);
        send_text("\"");
        send_eoi();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_QUOTE;
        cfg_data     = 8'd0;
        in_valid     = 1'b0;
        in_byte      = 8'd0;
        end_of_input = 1'b0;
        calm         = 1'b0;
        hold_go      = 1'b0;
        cur_quote    = QUOTE_RESET;
        cur_delim    = DELIMITER_RESET;
        words_sent   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        settle();

        for (int p = 0; p < 7; p++)
        begin
            set_config(quote_set[p], delim_set[p]);
            calm = (p == 1);
            if (p == 2)
                hold_go = 1'b1;
            send_records(245);
            calm = 1'b0;
            settle();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
